/* rtl/dxt1_block_decoder_core_macros.svh */
// Assertion macros shared by the decoder RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef DXT1_BLOCK_DECODER_CORE_MACROS_SVH
`define DXT1_BLOCK_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Consequent checked in the same cycle as the antecedent.
`define DXT1_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dxt1 check failed");
// Consequent checked in the cycle after the antecedent.
`define DXT1_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dxt1 check failed");
`else
`define DXT1_ASSERT_NOW(label, ante, cons)
`define DXT1_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/dxt1_pkg.sv */
package dxt1_pkg;

    // Block queue depth between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Texels per 4x4 block
    localparam int TEXELS     = 16;
    localparam int TEXEL_CNT_W = 4;
    localparam logic [TEXEL_CNT_W-1:0] LAST_TEXEL = TEXEL_CNT_W'(TEXELS - 1);

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [31:0] TRANSPARENT_BLACK = 32'h0000_0000;

    // x/3 == (x * 683) >> 11 for every x below 2048
    localparam logic [10:0] RECIP3       = 11'd683;
    localparam int          RECIP3_SHIFT = 11;

    // One decoded block: four palette colors and the index word
    typedef struct packed {
        logic [3:0][31:0] pal;
        logic [31:0]      idx;
    } blk_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // RGB565 to ABGR8888, shift only, opaque
    function automatic logic [31:0] expand565(input logic [15:0] c);
        return {ALPHA_OPAQUE, c[4:0], 3'b000, c[10:5], 2'b00, c[15:11], 3'b000};
    endfunction

    // Exact floor(x/3) for a 10-bit sum up to 767
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'(RECIP3);
        return p[RECIP3_SHIFT +: 8];
    endfunction

    // (2*near + far) / 3 per color channel, opaque
    function automatic logic [31:0] blend_third(input logic [31:0] near, input logic [31:0] far);
        logic [31:0] res;
        logic [9:0]  s;
        res = {ALPHA_OPAQUE, 24'h0};
        for (int ch = 0; ch < 3; ch++) begin
            s = {1'b0, near[ch*8 +: 8], 1'b0} + 10'(far[ch*8 +: 8]);
            res[ch*8 +: 8] = div3(s);
        end
        return res;
    endfunction

    // (a + b) / 2 per color channel, opaque
    function automatic logic [31:0] blend_half(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] res;
        logic [8:0]  s;
        res = {ALPHA_OPAQUE, 24'h0};
        for (int ch = 0; ch < 3; ch++) begin
            s = 9'(a[ch*8 +: 8]) + 9'(b[ch*8 +: 8]);
            res[ch*8 +: 8] = s[8:1];
        end
        return res;
    endfunction

endpackage

/* rtl/dxt1_in_if.sv */
interface dxt1_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_color;
    logic [15:0] second_color;
    logic [31:0] index_bits;

    modport source (output valid, first_color, second_color, index_bits, input ready);
    modport sink   (input valid, first_color, second_color, index_bits, output ready);
endinterface

/* rtl/dxt1_out_if.sv */
interface dxt1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] texel;
    logic [1:0]  row;
    logic [1:0]  column;
    logic        last;

    modport source (output valid, texel, row, column, last, input ready);
    modport sink   (input valid, texel, row, column, last, output ready);
endinterface

/* rtl/dxt1_block_decoder_core.sv */
// DXT1 block decoder: takes one compressed 4x4 block (two RGB565 endpoints and
// sixteen 2-bit indices) per input transaction and returns its sixteen texels
// as ABGR8888 in raster order, one texel per output transaction, with last set
// on the sixteenth. The front builds the palette in the cycle a block is taken
// and writes it into a two-entry block queue; the back unit reads one block at
// a time and emits one texel per cycle into an output register while out_ch
// is not stalled by ready. A block's first texel passes through the queue
// entry, the current-block register and the output register. Up to two further
// blocks are buffered while a block drains, so input can run ahead of output.
module dxt1_block_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    dxt1_in_if.sink    in_ch,
    dxt1_out_if.source out_ch
);
    import dxt1_pkg::*;

    q_stat_t stat;
    logic    push;
    logic    pop;
    blk_t    push_data;
    blk_t    pop_data;

    dxt1_front u_front (
        .in_ch (in_ch),
        .stat  (stat),
        .push  (push),
        .blk   (push_data)
    );

    dxt1_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    dxt1_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .stat   (stat),
        .q_data (pop_data),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

/* rtl/dxt1_front.sv */
// Accepts compressed blocks and builds the four-entry palette.
module dxt1_front (
    dxt1_in_if.sink          in_ch,
    input  dxt1_pkg::q_stat_t stat,
    output logic             push,
    output dxt1_pkg::blk_t   blk
);
    import dxt1_pkg::*;

    logic [31:0] col_a;
    logic [31:0] col_b;
    logic        four_color;

    // Take a block whenever the queue has room
    assign in_ch.ready = !stat.full;
    assign push        = in_ch.valid && !stat.full;

    // Endpoint expansion and mode select
    assign col_a      = expand565(in_ch.first_color);
    assign col_b      = expand565(in_ch.second_color);
    assign four_color = in_ch.first_color > in_ch.second_color;

    // Palette
    always_comb
    begin
        blk.pal[0] = col_a;
        blk.pal[1] = col_b;
        if (four_color)
        begin
            blk.pal[2] = blend_third(col_a, col_b);
            blk.pal[3] = blend_third(col_b, col_a);
        end
        else
        begin
            blk.pal[2] = blend_half(col_a, col_b);
            blk.pal[3] = TRANSPARENT_BLACK;
        end
        blk.idx = in_ch.index_bits;
    end

endmodule

/* rtl/dxt1_queue.sv */
`include "dxt1_block_decoder_core_macros.svh"

// Small FIFO of decoded palettes between front and back.
module dxt1_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dxt1_pkg::blk_t    push_data,
    input  logic              pop,
    output dxt1_pkg::blk_t    pop_data,
    output dxt1_pkg::q_stat_t stat
);
    import dxt1_pkg::*;

    blk_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = entries_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    `DXT1_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `DXT1_ASSERT_NOW(a_pop_not_empty, pop, count_reg != '0)
    `DXT1_ASSERT_NOW(a_push_not_full, push, !stat.full)

endmodule

/* rtl/dxt1_back.sv */
`include "dxt1_block_decoder_core_macros.svh"

// Walks one palette block and emits its texels in raster order.
module dxt1_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dxt1_pkg::q_stat_t stat,
    input  dxt1_pkg::blk_t    q_data,
    output logic              pop,
    dxt1_out_if.source        out_ch
);
    import dxt1_pkg::*;

    blk_t                   cur_reg;
    logic                   cur_valid_reg;
    logic                   cur_valid_next;
    logic [TEXEL_CNT_W-1:0] cnt_reg;
    logic [TEXEL_CNT_W-1:0] cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [31:0]            texel_reg;
    logic [1:0]             row_reg;
    logic [1:0]             column_reg;
    logic                   last_reg;
    logic                   fire;
    logic                   done;
    logic [1:0]             sel;

    // Produce a texel when the output register is free or draining
    assign fire = cur_valid_reg && (!out_valid_reg || out_ch.ready);
    assign done = fire && (cnt_reg == LAST_TEXEL);
    assign pop  = !stat.empty && (!cur_valid_reg || done);

    // Index of texel k sits at bits 2*(15-k)+1 .. 2*(15-k)
    assign sel = cur_reg.idx[{~cnt_reg, 1'b0} +: 2];

    // Control
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        cnt_next = fire ? cnt_reg + 1'b1 : cnt_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Block and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_data;
        end
        if (fire)
        begin
            texel_reg  <= cur_reg.pal[sel];
            row_reg    <= cnt_reg[3:2];
            column_reg <= cnt_reg[1:0];
            last_reg   <= (cnt_reg == LAST_TEXEL);
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.texel  = texel_reg;
    assign out_ch.row    = row_reg;
    assign out_ch.column = column_reg;
    assign out_ch.last   = last_reg;

    `DXT1_ASSERT_NOW(a_pop_on_boundary, pop, !cur_valid_reg || done)
    `DXT1_ASSERT_NEXT(a_block_starts_at_zero, pop, cnt_reg == '0)
    `DXT1_ASSERT_NEXT(a_fire_loads_output, fire, out_valid_reg && (last_reg == ($past(cnt_reg) == LAST_TEXEL)))

endmodule
